// ===== hw/rtl/crgs_pkg.sv =====
// Shared types and constants for the color ramp gradient sampler.
`default_nettype none
package crgs_pkg;

    localparam int POS_W   = 18;
    localparam int COL_W   = 16;
    localparam int CNT_W   = 5;
    localparam int SLOT_W  = 4;
    localparam int IDX_W   = 8;
    localparam int PROD_W  = 34;

    localparam logic [COL_W-1:0] COL_ZERO = 16'h0000;
    localparam logic [COL_W-1:0] COL_FULL = 16'hFFFF;
    localparam logic signed [POS_W-1:0] POS_ONE = 18'sd65280;
    localparam logic [CNT_W-1:0] COUNT_RESET = 5'd2;

    // Command codes of an input transaction.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // One RGBA color of a ramp stop.
    typedef struct packed {
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
        logic [COL_W-1:0] alpha;
    } t_color;

endpackage
`default_nettype wire

// ===== hw/rtl/crgs_stop_mem.sv =====
// Stop storage: position and color memories with registered reads.
`default_nettype none
module crgs_stop_mem #(
    parameter int MAX_STOPS = 16,
    parameter int AW = $clog2(MAX_STOPS)
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_wr_en,
    input  wire [AW-1:0]                         i_wr_addr,
    input  wire signed [crgs_pkg::POS_W-1:0]     i_wr_pos,
    input  wire crgs_pkg::t_color                i_wr_col,
    input  wire [AW-1:0]                         i_rd_a_addr,
    input  wire [AW-1:0]                         i_rd_b_addr,
    output logic signed [crgs_pkg::POS_W-1:0]    o_rd_a_pos,
    output crgs_pkg::t_color                     o_rd_a_col,
    output crgs_pkg::t_color                     o_rd_b_col
);

    logic signed [crgs_pkg::POS_W-1:0] r_pos_mem [MAX_STOPS];
    crgs_pkg::t_color                  r_col_mem [MAX_STOPS];
    logic [MAX_STOPS-1:0]              r_wr_vld;

    logic signed [crgs_pkg::POS_W-1:0] r_a_pos;
    crgs_pkg::t_color                  r_a_col;
    crgs_pkg::t_color                  r_b_col;
    logic                              r_a_vld;
    logic                              r_b_vld;
    logic [AW-1:0]                     r_a_addr;
    logic [AW-1:0]                     r_b_addr;

    // Written-entry flags; an unwritten entry reads as its reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_vld <= '0;
        end else if (i_wr_en) begin
            r_wr_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Memory write and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_pos_mem[i_wr_addr] <= i_wr_pos;
            r_col_mem[i_wr_addr] <= i_wr_col;
        end
        r_a_pos  <= r_pos_mem[i_rd_a_addr];
        r_a_col  <= r_col_mem[i_rd_a_addr];
        r_b_col  <= r_col_mem[i_rd_b_addr];
        r_a_addr <= i_rd_a_addr;
        r_b_addr <= i_rd_b_addr;
        r_a_vld  <= r_wr_vld[i_rd_a_addr];
        r_b_vld  <= r_wr_vld[i_rd_b_addr];
    end

    // Reset contents of the two default stops.
    function automatic crgs_pkg::t_color reset_col(input logic [AW-1:0] addr);
        crgs_pkg::t_color c;
        c = '{crgs_pkg::COL_ZERO, crgs_pkg::COL_ZERO, crgs_pkg::COL_ZERO,
              crgs_pkg::COL_ZERO};
        if (addr == AW'(0)) begin
            c.alpha = crgs_pkg::COL_FULL;
        end else if (addr == AW'(1)) begin
            c = '{crgs_pkg::COL_FULL, crgs_pkg::COL_FULL, crgs_pkg::COL_FULL,
                  crgs_pkg::COL_FULL};
        end
        return c;
    endfunction

    always_comb begin
        if (r_a_vld) begin
            o_rd_a_pos = r_a_pos;
        end else if (r_a_addr == AW'(1)) begin
            o_rd_a_pos = crgs_pkg::POS_ONE;
        end else begin
            o_rd_a_pos = '0;
        end
        o_rd_a_col = r_a_vld ? r_a_col : reset_col(r_a_addr);
        o_rd_b_col = r_b_vld ? r_b_col : reset_col(r_b_addr);
    end

endmodule
`default_nettype wire

// ===== hw/rtl/crgs_lerp.sv =====
// One color channel: multiply then bit-serial divide for the interpolation.
`default_nettype none
module crgs_lerp (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_start,
    input  wire [crgs_pkg::COL_W-1:0]          i_lo,
    input  wire [crgs_pkg::COL_W-1:0]          i_hi,
    input  wire [crgs_pkg::POS_W-1:0]          i_rel,
    input  wire [crgs_pkg::POS_W-1:0]          i_seg,
    output logic                               o_done,
    output logic [crgs_pkg::COL_W-1:0]         o_value
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    logic [1:0]                       r_ph;
    logic [3:0]                       r_bit;
    logic signed [crgs_pkg::COL_W:0]  r_d;
    logic [crgs_pkg::COL_W-1:0]       r_lo;
    logic [crgs_pkg::POS_W-1:0]       r_rel;
    logic [crgs_pkg::POS_W-1:0]       r_seg;
    logic                             r_neg;
    logic [crgs_pkg::PROD_W-1:0]      r_rem;
    logic [crgs_pkg::PROD_W-1:0]      r_dv;
    logic [crgs_pkg::COL_W-1:0]       r_q;
    logic                             r_done;
    logic [crgs_pkg::COL_W-1:0]       r_value;

    logic [crgs_pkg::COL_W-1:0]       w_abs_d;
    logic                             w_ge;
    logic [crgs_pkg::COL_W-1:0]       w_sq;

    assign w_abs_d = r_d[crgs_pkg::COL_W] ? crgs_pkg::COL_W'(-r_d) : r_d[crgs_pkg::COL_W-1:0];
    assign w_ge    = (r_rem >= r_dv);
    assign w_sq    = r_neg ? (~r_q + 16'd1) : r_q;

    // Phase sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_ph)
                PH_IDLE: begin
                    if (i_start) begin
                        r_ph <= PH_MUL;
                    end
                end
                PH_MUL: begin
                    r_ph <= PH_DIV;
                end
                PH_DIV: begin
                    if (r_bit == 4'd0) begin
                        r_ph <= PH_FIN;
                    end
                end
                PH_FIN: begin
                    r_ph   <= PH_IDLE;
                    r_done <= 1'b1;
                end
                default: begin
                    r_ph <= PH_IDLE;
                end
            endcase
        end
    end

    // Datapath: magnitude product, restoring division, signed add-back.
    always_ff @(posedge i_clk) begin
        case (r_ph)
            PH_IDLE: begin
                r_d   <= $signed({1'b0, i_hi}) - $signed({1'b0, i_lo});
                r_lo  <= i_lo;
                r_rel <= i_rel;
                r_seg <= i_seg;
            end
            PH_MUL: begin
                r_neg <= r_d[crgs_pkg::COL_W];
                r_rem <= crgs_pkg::PROD_W'(w_abs_d) * crgs_pkg::PROD_W'(r_rel);
                r_dv  <= {1'b0, r_seg, 15'd0};
                r_bit <= 4'd15;
                r_q   <= '0;
            end
            PH_DIV: begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dv;
                end
                r_q   <= {r_q[crgs_pkg::COL_W-2:0], w_ge};
                r_dv  <= r_dv >> 1;
                r_bit <= r_bit - 4'd1;
            end
            PH_FIN: begin
                r_value <= r_lo + w_sq;
            end
            default: begin
            end
        endcase
    end

    assign o_done  = r_done;
    assign o_value = r_value;

endmodule
`default_nettype wire

// ===== hw/rtl/color_ramp_gradient_sampler.sv =====
// Top level of the color ramp gradient sampler: stop scan and control.
// An evaluate transaction scans n stops, where n is stop_count limited to MAX_STOPS, then picks
// the bracketing pair and runs the four channel dividers before it strobes its result.
// Busy stays high until the strobe cycle, so a new evaluate is accepted only once busy is low.
// A write transaction completes at its accepting edge; busy stays low. With no stops the
// result strobes in the cycle after start. Synchronous active-low reset restores the defaults.
`default_nettype none
module color_ramp_gradient_sampler #(
    parameter int MAX_STOPS = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire                                i_cfg_we,
    input  wire [crgs_pkg::CNT_W-1:0]          i_cfg_wdata,
    input  wire                                i_command,
    input  wire [crgs_pkg::SLOT_W-1:0]         i_slot,
    input  wire signed [crgs_pkg::POS_W-1:0]   i_position,
    input  wire [crgs_pkg::COL_W-1:0]          i_red_in,
    input  wire [crgs_pkg::COL_W-1:0]          i_green_in,
    input  wire [crgs_pkg::COL_W-1:0]          i_blue_in,
    input  wire [crgs_pkg::COL_W-1:0]          i_alpha_in,
    input  wire [crgs_pkg::IDX_W-1:0]          i_sample_index,
    output logic                               o_valid,
    output logic [crgs_pkg::COL_W-1:0]         o_red_out,
    output logic [crgs_pkg::COL_W-1:0]         o_green_out,
    output logic [crgs_pkg::COL_W-1:0]         o_blue_out,
    output logic [crgs_pkg::COL_W-1:0]         o_alpha_out
);

    localparam int AW = $clog2(MAX_STOPS);
    localparam int CW = $clog2(MAX_STOPS + 1);
    localparam int PW = crgs_pkg::POS_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_DEC  = 3'd2;
    localparam logic [2:0] ST_CRD  = 3'd3;
    localparam logic [2:0] ST_LST  = 3'd4;
    localparam logic [2:0] ST_LWT  = 3'd5;

    localparam logic [CW-1:0] ONE_CNT = CW'(1);

    logic [2:0]                 r_state;
    logic [crgs_pkg::CNT_W-1:0] r_stop_count;
    logic [CW-1:0]              r_n;
    logic [CW-1:0]              r_cnt;
    logic                       r_chk;
    logic [AW-1:0]              r_chk_addr;
    logic signed [PW-1:0]       r_p;
    logic                       r_any;
    logic signed [PW-1:0]       r_min_pos;
    logic [AW-1:0]              r_min_slot;
    logic signed [PW-1:0]       r_max_pos;
    logic [AW-1:0]              r_max_slot;
    logic                       r_lo_f;
    logic signed [PW-1:0]       r_lo_pos;
    logic [AW-1:0]              r_lo_slot;
    logic                       r_hi_f;
    logic signed [PW-1:0]       r_hi_pos;
    logic [AW-1:0]              r_hi_slot;
    logic [AW-1:0]              r_a_slot;
    logic [AW-1:0]              r_b_slot;
    logic [PW-1:0]              r_rel;
    logic [PW-1:0]              r_seg;
    logic                       r_valid;
    crgs_pkg::t_color           r_out;

    logic [8:0]                 w_cnt_wide;
    logic [CW-1:0]              w_n;
    logic [7:0]                 w_slot_wide;
    logic                       w_accept;
    logic                       w_wr_en;
    logic [AW-1:0]              w_rd_a_addr;
    logic signed [PW-1:0]       w_pos;
    crgs_pkg::t_color           w_col_a;
    crgs_pkg::t_color           w_col_b;
    crgs_pkg::t_color           w_wr_col;
    logic [3:0]                 w_done;
    crgs_pkg::t_color           w_lerp_out;
    logic signed [PW:0]         w_rel_full;
    logic signed [PW:0]         w_seg_full;

    // Effective stop count, limited to the storage depth.
    assign w_cnt_wide  = 9'(r_stop_count);
    assign w_n         = (w_cnt_wide > 9'(MAX_STOPS)) ? CW'(MAX_STOPS) : CW'(r_stop_count);
    assign w_slot_wide = 8'(i_slot);
    assign w_accept    = start && !busy;
    assign w_wr_en     = w_accept && (i_command == crgs_pkg::CMD_WRITE) &&
                         (9'(i_slot) < 9'(MAX_STOPS));
    assign w_wr_col    = '{i_red_in, i_green_in, i_blue_in, i_alpha_in};
    assign w_rd_a_addr = (r_state == ST_SCAN) ? r_cnt[AW-1:0] : r_a_slot;
    assign w_rel_full  = (PW + 1)'(r_p) - (PW + 1)'(r_lo_pos);
    assign w_seg_full  = (PW + 1)'(r_hi_pos) - (PW + 1)'(r_lo_pos);

    crgs_stop_mem #(
        .MAX_STOPS (MAX_STOPS),
        .AW        (AW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_slot_wide[AW-1:0]),
        .i_wr_pos    (i_position),
        .i_wr_col    (w_wr_col),
        .i_rd_a_addr (w_rd_a_addr),
        .i_rd_b_addr (r_b_slot),
        .o_rd_a_pos  (w_pos),
        .o_rd_a_col  (w_col_a),
        .o_rd_b_col  (w_col_b)
    );

    // One interpolation lane per color channel.
    crgs_lerp u_lerp_r (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (r_state == ST_LST),
        .i_lo (w_col_a.red), .i_hi (w_col_b.red), .i_rel (r_rel), .i_seg (r_seg),
        .o_done (w_done[0]), .o_value (w_lerp_out.red)
    );
    crgs_lerp u_lerp_g (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (r_state == ST_LST),
        .i_lo (w_col_a.green), .i_hi (w_col_b.green), .i_rel (r_rel), .i_seg (r_seg),
        .o_done (w_done[1]), .o_value (w_lerp_out.green)
    );
    crgs_lerp u_lerp_b (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (r_state == ST_LST),
        .i_lo (w_col_a.blue), .i_hi (w_col_b.blue), .i_rel (r_rel), .i_seg (r_seg),
        .o_done (w_done[2]), .o_value (w_lerp_out.blue)
    );
    crgs_lerp u_lerp_a (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (r_state == ST_LST),
        .i_lo (w_col_a.alpha), .i_hi (w_col_b.alpha), .i_rel (r_rel), .i_seg (r_seg),
        .o_done (w_done[3]), .o_value (w_lerp_out.alpha)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count <= crgs_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            r_stop_count <= i_cfg_wdata;
        end
    end

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_chk   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_chk <= 1'b0;
                    if (w_accept && (i_command == crgs_pkg::CMD_EVAL)) begin
                        if (w_n == '0) begin
                            r_valid <= 1'b1;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    r_chk <= (r_cnt < r_n);
                    if (r_cnt == r_n && !r_chk) begin
                        r_state <= ST_DEC;
                    end
                end
                ST_DEC: begin
                    r_state <= ST_CRD;
                end
                ST_CRD: begin
                    r_state <= ST_LST;
                end
                ST_LST: begin
                    r_state <= ST_LWT;
                end
                ST_LWT: begin
                    if (&w_done) begin
                        r_valid <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Scan datapath: track the extreme stops and the bracketing pair, pick the pair, capture the result.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_n      <= w_n;
                r_cnt    <= '0;
                r_p      <= $signed({2'b00, i_sample_index, 8'h00});
                r_any    <= 1'b0;
                r_lo_f   <= 1'b0;
                r_hi_f   <= 1'b0;
                r_out    <= '{crgs_pkg::COL_ZERO, crgs_pkg::COL_ZERO,
                              crgs_pkg::COL_ZERO, crgs_pkg::COL_FULL};
            end
            ST_SCAN: begin
                if (r_cnt < r_n) begin
                    r_cnt <= r_cnt + ONE_CNT;
                end
                r_chk_addr <= r_cnt[AW-1:0];
                if (r_chk) begin
                    r_any <= 1'b1;
                    if (!r_any || w_pos < r_min_pos) begin
                        r_min_pos  <= w_pos;
                        r_min_slot <= r_chk_addr;
                    end
                    if (!r_any || w_pos >= r_max_pos) begin
                        r_max_pos  <= w_pos;
                        r_max_slot <= r_chk_addr;
                    end
                    if (w_pos <= r_p && (!r_lo_f || w_pos >= r_lo_pos)) begin
                        r_lo_f    <= 1'b1;
                        r_lo_pos  <= w_pos;
                        r_lo_slot <= r_chk_addr;
                    end
                    if (w_pos > r_p && (!r_hi_f || w_pos < r_hi_pos)) begin
                        r_hi_f    <= 1'b1;
                        r_hi_pos  <= w_pos;
                        r_hi_slot <= r_chk_addr;
                    end
                end
            end
            ST_DEC: begin
                if (r_p <= r_min_pos) begin
                    r_a_slot <= r_min_slot;
                    r_b_slot <= r_min_slot;
                    r_rel    <= '0;
                    r_seg    <= PW'(1);
                end else if (!r_hi_f) begin
                    r_a_slot <= r_max_slot;
                    r_b_slot <= r_max_slot;
                    r_rel    <= '0;
                    r_seg    <= PW'(1);
                end else begin
                    r_a_slot <= r_lo_slot;
                    r_b_slot <= r_hi_slot;
                    r_rel    <= w_rel_full[PW-1:0];
                    r_seg    <= w_seg_full[PW-1:0];
                end
            end
            ST_LWT: begin
                if (&w_done) begin
                    r_out <= w_lerp_out;
                end
            end
            default: begin
            end
        endcase
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_red_out   = r_out.red;
    assign o_green_out = r_out.green;
    assign o_blue_out  = r_out.blue;
    assign o_alpha_out = r_out.alpha;

endmodule
`default_nettype wire

// ===== hw/rtl/crgs_checker.sv =====
// Port-level checker for the color ramp gradient sampler, bound to the top level.
`default_nettype none
module crgs_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire start,
    input wire busy,
    input wire i_command,
    input wire o_valid
);

    // A write transaction never produces a result.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == crgs_pkg::CMD_WRITE)) |=> !o_valid)
        else $error("result strobe after a write transaction");

    // An evaluate transaction either strobes at once or goes busy.
    a_eval_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == crgs_pkg::CMD_EVAL)) |=> (busy || o_valid))
        else $error("evaluate transaction neither busy nor answered");

    // A result strobes only with the block idle.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // Finishing an evaluation always delivers its result.
    a_fall_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    // Reset leaves the block idle and quiet.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_valid))
        else $error("block not idle after reset");

endmodule

bind color_ramp_gradient_sampler crgs_checker u_crgs_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_command (i_command),
    .o_valid   (o_valid)
);
`default_nettype wire
